// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SMI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/smi_pkg.sv =====
`timescale 1ns / 1ps

package smi_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_SINGULAR  = 2'd1;
    localparam status_t STATUS_SATURATED = 2'd2;

    localparam int NUM_ENTRIES = 9;
    localparam int DET_TERMS   = 3;

    // adj[k] = a[P]*a[Q] - a[S]*a[T]
    localparam int CROSS_P [NUM_ENTRIES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CROSS_Q [NUM_ENTRIES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CROSS_S [NUM_ENTRIES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CROSS_T [NUM_ENTRIES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // expansion along row 0 uses adjugate entries of column 0
    localparam int DET_COF [DET_TERMS] = '{0, 3, 6};

endpackage

// ===== rtl/core/smi_if.sv =====
`timescale 1ns / 1ps

interface smi_mat_if
    import smi_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
();
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] a00;
    logic signed [DATA_WIDTH-1:0] a01;
    logic signed [DATA_WIDTH-1:0] a02;
    logic signed [DATA_WIDTH-1:0] a10;
    logic signed [DATA_WIDTH-1:0] a11;
    logic signed [DATA_WIDTH-1:0] a12;
    logic signed [DATA_WIDTH-1:0] a20;
    logic signed [DATA_WIDTH-1:0] a21;
    logic signed [DATA_WIDTH-1:0] a22;

    modport source (
        output valid, mode, a00, a01, a02, a10, a11, a12, a20, a21, a22,
        input  ready
    );
    modport sink (
        input  valid, mode, a00, a01, a02, a10, a11, a12, a20, a21, a22,
        output ready
    );
endinterface

interface smi_inv_if
    import smi_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] r00;
    logic signed [DATA_WIDTH-1:0] r01;
    logic signed [DATA_WIDTH-1:0] r02;
    logic signed [DATA_WIDTH-1:0] r10;
    logic signed [DATA_WIDTH-1:0] r11;
    logic signed [DATA_WIDTH-1:0] r12;
    logic signed [DATA_WIDTH-1:0] r20;
    logic signed [DATA_WIDTH-1:0] r21;
    logic signed [DATA_WIDTH-1:0] r22;
    status_t                      status;

    modport source (
        output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, status,
        input  ready
    );
    modport sink (
        input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, status,
        output ready
    );
endinterface

// ===== rtl/core/small_matrix_inverse.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Modport  Transfer moves
// mat      sink     mode, a00..a22 (one 2x2 or 3x3 matrix)
// inv      source   r00..r22, status (its inverse)
//
// One matrix accepted per cycle while mat.ready is high. The path runs through six
// cofactor/determinant stages, a divider of DATA_WIDTH + 3 stages (one quotient
// bit per iteration stage) and one output register that drives inv.valid.
// rst_n clears only the valid bits of the pipeline, output and skid registers.
// A stall on inv fills the skid register; mat.ready drops and the pipeline holds while it is full.

module small_matrix_inverse
    import smi_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input logic       clk,
    input logic       rst_n,
    smi_mat_if.sink   mat,
    smi_inv_if.source inv
);

    localparam int W       = DATA_WIDTH;
    localparam int PW      = 2*W;
    localparam int CW      = 2*W + 1;
    localparam int TW      = 2*W + 1;
    localparam int DW      = 3*W + 3;
    localparam int CMW     = 2*W;
    localparam int DMW     = 3*W;
    localparam int DIV_LAT = W + 3;

    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    logic en;

    logic signed [W-1:0] a_in [NUM_ENTRIES];

    logic                v1_reg;
    logic                mode1_reg;
    logic signed [W-1:0] a1_reg [NUM_ENTRIES];

    logic                 v2_reg;
    logic                 mode2_reg;
    logic signed [PW-1:0] pp2_reg [NUM_ENTRIES];
    logic signed [PW-1:0] pn2_reg [NUM_ENTRIES];
    logic signed [W-1:0]  a2_reg  [NUM_ENTRIES];

    logic signed [CW-1:0] cross_c [NUM_ENTRIES];
    logic signed [CW-1:0] adj_c   [NUM_ENTRIES];

    logic                 v3_reg;
    logic                 mode3_reg;
    logic signed [CW-1:0] adj3_reg [NUM_ENTRIES];
    logic signed [CW-1:0] det23_reg;
    logic signed [W-1:0]  a3_reg   [DET_TERMS];

    logic signed [TW-1:0] lo_c [DET_TERMS];
    logic signed [TW-1:0] hi_c [DET_TERMS];

    logic                 v4_reg;
    logic                 mode4_reg;
    logic signed [CW-1:0] adj4_reg [NUM_ENTRIES];
    logic signed [CW-1:0] det24_reg;
    logic signed [TW-1:0] lo4_reg  [DET_TERMS];
    logic signed [TW-1:0] hi4_reg  [DET_TERMS];

    logic signed [DW-1:0] det_c;

    logic                 v5_reg;
    logic signed [CW-1:0] adj5_reg [NUM_ENTRIES];
    logic signed [DW-1:0] det5_reg;

    logic signed [CW-1:0] adj_abs_c [NUM_ENTRIES];
    logic signed [DW-1:0] det_abs_c;

    logic           v6_reg;
    logic [CMW-1:0] cmag6_reg [NUM_ENTRIES];
    logic [DMW-1:0] dmag6_reg;
    logic           neg6_reg  [NUM_ENTRIES];
    logic           sing6_reg;

    logic signed [W-1:0]   res [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] ovf;

    logic vd_reg [DIV_LAT];
    logic sd_reg [DIV_LAT];

    logic signed [W-1:0] pipe_res [NUM_ENTRIES];
    status_t             pipe_stat;
    logic                pipe_v;

    logic                ov_reg;
    logic signed [W-1:0] out_res_reg [NUM_ENTRIES];
    status_t             out_stat_reg;
    logic                skid_v_reg;
    logic signed [W-1:0] skid_res_reg [NUM_ENTRIES];
    status_t             skid_stat_reg;
    logic                pop;

    assign en        = !skid_v_reg;
    assign mat.ready = en;

    always_comb
    begin
        a_in[0] = mat.a00;
        a_in[1] = mat.a01;
        a_in[2] = mat.a02;
        a_in[3] = mat.a10;
        a_in[4] = mat.a11;
        a_in[5] = mat.a12;
        a_in[6] = mat.a20;
        a_in[7] = mat.a21;
        a_in[8] = mat.a22;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= mat.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            vd_reg[0] <= v6_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                vd_reg[k] <= vd_reg[k-1];
            end
        end
    end

    // cofactor differences; two-by-two takes its adjugate straight from the entries
    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            cross_c[k] = CW'(pp2_reg[k]) - CW'(pn2_reg[k]);
        end
        if (mode2_reg)
        begin
            adj_c = cross_c;
        end
        else
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                adj_c[k] = '0;
            end
            adj_c[0] = CW'(a2_reg[4]);
            adj_c[1] = -CW'(a2_reg[1]);
            adj_c[3] = -CW'(a2_reg[3]);
            adj_c[4] = CW'(a2_reg[0]);
        end
    end

    // split each determinant cofactor into a signed high half and an unsigned low half
    always_comb
    begin
        for (int j = 0; j < DET_TERMS; j++)
        begin
            lo_c[j] = a3_reg[j] * $signed({1'b0, adj3_reg[DET_COF[j]][W-1:0]});
            hi_c[j] = a3_reg[j] * $signed(adj3_reg[DET_COF[j]][CW-1:W]);
        end
    end

    always_comb
    begin
        det_c = '0;
        if (mode4_reg)
        begin
            for (int j = 0; j < DET_TERMS; j++)
            begin
                det_c = det_c + (DW'(hi4_reg[j]) <<< W) + DW'(lo4_reg[j]);
            end
        end
        else
        begin
            det_c = DW'(det24_reg);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            adj_abs_c[k] = adj5_reg[k][CW-1] ? -adj5_reg[k] : adj5_reg[k];
        end
        det_abs_c = det5_reg[DW-1] ? -det5_reg : det5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= mat.mode;
            a1_reg    <= a_in;

            mode2_reg <= mode1_reg;
            a2_reg    <= a1_reg;
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                pp2_reg[k] <= a1_reg[CROSS_P[k]] * a1_reg[CROSS_Q[k]];
                pn2_reg[k] <= a1_reg[CROSS_S[k]] * a1_reg[CROSS_T[k]];
            end

            mode3_reg <= mode2_reg;
            adj3_reg  <= adj_c;
            det23_reg <= cross_c[8];
            for (int j = 0; j < DET_TERMS; j++)
            begin
                a3_reg[j] <= a2_reg[j];
            end

            mode4_reg <= mode3_reg;
            adj4_reg  <= adj3_reg;
            det24_reg <= det23_reg;
            lo4_reg   <= lo_c;
            hi4_reg   <= hi_c;

            adj5_reg <= adj4_reg;
            det5_reg <= det_c;

            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                cmag6_reg[k] <= adj_abs_c[k][CMW-1:0];
                neg6_reg[k]  <= adj5_reg[k][CW-1] ^ det5_reg[DW-1];
            end
            dmag6_reg <= det_abs_c[DMW-1:0];
            sing6_reg <= det5_reg == '0;

            sd_reg[0] <= sing6_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_ENTRIES; k++)
    begin : g_div
        smi_div #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_div (
            .clk  (clk),
            .en   (en),
            .cmag (cmag6_reg[k]),
            .dmag (dmag6_reg),
            .neg  (neg6_reg[k]),
            .quo  (res[k]),
            .ovf  (ovf[k])
        );
    end

    always_comb
    begin
        pipe_v = vd_reg[DIV_LAT-1] && en;
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            pipe_res[k] = sd_reg[DIV_LAT-1] ? '0 : res[k];
        end
        priority if (sd_reg[DIV_LAT-1])
        begin
            pipe_stat = STATUS_SINGULAR;
        end
        else if (|ovf)
        begin
            pipe_stat = STATUS_SATURATED;
        end
        else
        begin
            pipe_stat = STATUS_OK;
        end
    end

    assign pop = ov_reg && inv.ready;

    // output register with a skid stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg     <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (pop || !ov_reg)
        begin
            if (skid_v_reg)
            begin
                ov_reg     <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                ov_reg <= pipe_v;
            end
        end
        else if (pipe_v)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !ov_reg)
        begin
            if (skid_v_reg)
            begin
                out_res_reg  <= skid_res_reg;
                out_stat_reg <= skid_stat_reg;
            end
            else
            begin
                out_res_reg  <= pipe_res;
                out_stat_reg <= pipe_stat;
            end
        end
        else if (pipe_v)
        begin
            skid_res_reg  <= pipe_res;
            skid_stat_reg <= pipe_stat;
        end
    end

    assign inv.valid  = ov_reg;
    assign inv.r00    = out_res_reg[0];
    assign inv.r01    = out_res_reg[1];
    assign inv.r02    = out_res_reg[2];
    assign inv.r10    = out_res_reg[3];
    assign inv.r11    = out_res_reg[4];
    assign inv.r12    = out_res_reg[5];
    assign inv.r20    = out_res_reg[6];
    assign inv.r21    = out_res_reg[7];
    assign inv.r22    = out_res_reg[8];
    assign inv.status = out_stat_reg;

    `SMI_ASSERT(a_skid_behind_out, skid_v_reg |-> ov_reg, "skid full with output register empty")
    `SMI_ASSERT(a_skid_fill, $rose(skid_v_reg) |-> $past(ov_reg && !inv.ready), "skid filled without a stall")
    `SMI_ASSERT(a_sing_zero, inv.valid && inv.status == STATUS_SINGULAR |-> inv.r00 == '0 && inv.r11 == '0 && inv.r22 == '0, "singular result not zero")

    for (genvar k = 0; k < NUM_ENTRIES; k++)
    begin : g_sat_chk
        `SMI_ASSERT(a_sat_bound, vd_reg[DIV_LAT-1] && ovf[k] |-> res[k] == SAT_MAX || res[k] == SAT_MIN, "saturated entry not at a bound")
    end

endmodule

// ===== rtl/core/smi_div.sv =====
`timescale 1ns / 1ps

module smi_div
    import smi_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [2*DATA_WIDTH-1:0]      cmag,
    input  logic [3*DATA_WIDTH-1:0]      dmag,
    input  logic                         neg,
    output logic signed [DATA_WIDTH-1:0] quo,
    output logic                         ovf
);

    localparam int W    = DATA_WIDTH;
    localparam int NW   = 4*W + 2*FRAC_BITS + 3;
    localparam int QW   = W + 1;
    localparam int ITER = W + 1;

    logic [NW-1:0] n0;
    logic [NW-1:0] d0;
    logic          big0;

    logic [NW-1:0] r_reg   [ITER];
    logic [NW-1:0] d_reg   [ITER];
    logic [QW-1:0] q_reg   [ITER+1];
    logic          neg_reg [ITER+1];
    logic          big_reg [ITER+1];

    logic [NW-1:0] sh     [ITER];
    logic [NW-1:0] r_next [ITER];
    logic [QW-1:0] q_next [ITER];

    logic [QW-1:0] lim;
    logic [QW-1:0] val;
    logic          sat;

    logic signed [W-1:0] quo_reg;
    logic                ovf_reg;

    // numerator 2|C|*2^(2F) + |D|, divisor 2|D|: rounds half away from zero
    always_comb
    begin
        n0   = (NW'(cmag) << (2*FRAC_BITS + 1)) + NW'(dmag);
        d0   = NW'(dmag) << 1;
        big0 = n0 >= (d0 << (W + 1));
    end

    always_comb
    begin
        for (int k = 0; k < ITER; k++)
        begin
            sh[k] = d_reg[k] << (W - k);
            if (r_reg[k] >= sh[k])
            begin
                r_next[k] = r_reg[k] - sh[k];
                q_next[k] = q_reg[k] | (QW'(1) << (W - k));
            end
            else
            begin
                r_next[k] = r_reg[k];
                q_next[k] = q_reg[k];
            end
        end
    end

    always_comb
    begin
        lim = neg_reg[ITER] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
        sat = big_reg[ITER] || (q_reg[ITER] > lim);
        val = sat ? lim : q_reg[ITER];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= n0;
            d_reg[0]   <= d0;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            big_reg[0] <= big0;
            for (int k = 0; k < ITER; k++)
            begin
                if (k < ITER - 1)
                begin
                    r_reg[k+1] <= r_next[k];
                    d_reg[k+1] <= d_reg[k];
                end
                q_reg[k+1]   <= q_next[k];
                neg_reg[k+1] <= neg_reg[k];
                big_reg[k+1] <= big_reg[k];
            end
            quo_reg <= neg_reg[ITER] ? -$signed(val[W-1:0]) : $signed(val[W-1:0]);
            ovf_reg <= sat;
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;

endmodule
